FILE: sv/sector_calibration_interpolator_defines.svh
`ifndef SECTOR_CALIBRATION_INTERPOLATOR_DEFINES_SVH
`define SECTOR_CALIBRATION_INTERPOLATOR_DEFINES_SVH

// Property checked at every clock edge outside reset.
`define SCI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition in one cycle implies a consequence in the same cycle.
`define SCI_ASSERT_IMP(lbl, cond, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |-> (cons)) \
    else $error(msg);

`endif

FILE: sv/sci_pkg.sv
`timescale 1ns / 1ps
package sci_pkg;

  localparam int SECTORS    = 8;
  localparam int MAX_POINTS = 16;
  localparam int FULL_TURN  = 360;
  localparam int SEC_SPAN   = FULL_TURN / SECTORS;

  localparam int OP_W      = 2;
  localparam int ANG_W     = 10;
  localparam int KEY_W     = 12;
  localparam int VAL_W     = 10;
  localparam int IDX_W     = $clog2(MAX_POINTS);
  localparam int CNT_W     = IDX_W;
  localparam int SEC_W     = $clog2(SECTORS);
  localparam int ADDR_W    = SEC_W + IDX_W;
  localparam int DVD_W     = KEY_W + VAL_W;
  localparam int DIV_CNT_W = $clog2(DVD_W + 1);
  localparam int IN_W      = 40;
  localparam int OUT_W     = 16;

  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(MAX_POINTS - 1);

  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
  localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;

  typedef enum logic [2:0] {
    RES_ZERO,
    RES_COUNT,
    RES_COUNT_INC,
    RES_AVG,
    RES_INTERP
  } res_sel_e;

  typedef struct packed {
    logic             load;
    logic             clr;
    logic             rd_en;
    logic [IDX_W-1:0] rd_idx;
    logic             wr_en;
    logic             wr_new;
    logic [IDX_W-1:0] wr_idx;
    logic             cnt_inc;
    logic             lat0;
    logic             lat1;
    logic             div_start;
    logic             res_en;
    res_sel_e         res_sel;
    logic             push;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [CNT_W-1:0] cnt;
    logic             key_gt;
    logic             key_lt;
    logic             k_eq;
    logic             div_done;
    logic             out_free;
  } dp_stat_t;

endpackage

FILE: sv/sector_calibration_interpolator.sv
`timescale 1ns / 1ps
// Channel  | Dir | Fields (low bit up)
// s_axis   | in  | operation[1:0] angle_deg[11:2] pixel_distance[23:12] real_cm[33:24]
// m_axis   | out | value[9:0]
//
// One item at a time. An insert compares the stored keys from the top down (up
// to 14), moving each larger key up one slot. A query scans the sector's keys one
// per cycle (up to 15), loads the segment, then runs a 22-step restoring divider
// unless the two segment keys are equal.
// Reset empties all sectors at once (counts cleared); no clearing pass.
// A finished result waits in the output register while the next item is taken.
module sector_calibration_interpolator (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid_i,
  output logic                       s_axis_tready_o,
  // operation, angle_deg, pixel_distance, real_cm, zero pad
  input  logic [sci_pkg::IN_W-1:0]   s_axis_tdata_i,
  output logic                       m_axis_tvalid_o,
  input  logic                       m_axis_tready_i,
  // value, zero pad
  output logic [sci_pkg::OUT_W-1:0]  m_axis_tdata_o
);

  sci_pkg::ctrl_cmd_t        cmd;
  sci_pkg::dp_stat_t         stat;
  logic [sci_pkg::VAL_W-1:0] value;

  sci_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  sci_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .op_i        (s_axis_tdata_i[1:0]),
    .angle_i     (s_axis_tdata_i[11:2]),
    .px_i        (s_axis_tdata_i[23:12]),
    .cm_i        (s_axis_tdata_i[33:24]),
    .out_ready_i (m_axis_tready_i),
    .stat_o      (stat),
    .out_valid_o (m_axis_tvalid_o),
    .out_value_o (value)
  );

  assign m_axis_tdata_o = {{(sci_pkg::OUT_W - sci_pkg::VAL_W){1'b0}}, value};

endmodule

FILE: sv/sci_div.sv
`timescale 1ns / 1ps
module sci_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [sci_pkg::DVD_W-1:0]   dividend_i,
  input  logic [sci_pkg::KEY_W-1:0]   divisor_i,
  output logic [sci_pkg::DVD_W-1:0]   quotient_o,
  output logic                        done_o
);

  logic                          busy_q, busy_d;
  logic                          done_q, done_d;
  logic [sci_pkg::DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [sci_pkg::KEY_W-1:0]     rem_q, rem_d;
  logic [sci_pkg::DVD_W-1:0]     quo_q, quo_d;
  logic [sci_pkg::KEY_W-1:0]     dsr_q, dsr_d;
  logic [sci_pkg::KEY_W:0]       shifted;
  logic                          fits;

  // one restoring step per cycle, quotient bits shift in behind the dividend
  assign shifted = {rem_q, quo_q[sci_pkg::DVD_W-1]};
  assign fits    = shifted >= {1'b0, dsr_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dsr_d  = dsr_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = sci_pkg::DIV_CNT_W'(sci_pkg::DVD_W);
      rem_d  = '0;
      quo_d  = dividend_i;
      dsr_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = fits ? sci_pkg::KEY_W'(shifted - {1'b0, dsr_q})
                   : shifted[sci_pkg::KEY_W-1:0];
      quo_d = {quo_q[sci_pkg::DVD_W-2:0], fits};
      cnt_d = cnt_q - sci_pkg::DIV_CNT_W'(1);
      if (cnt_q == sci_pkg::DIV_CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dsr_q <= dsr_d;
  end

  assign quotient_o = quo_q;
  assign done_o     = done_q;

endmodule

FILE: sv/sci_dpath.sv
`timescale 1ns / 1ps
module sci_dpath (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  sci_pkg::ctrl_cmd_t        cmd_i,
  input  logic [sci_pkg::OP_W-1:0]  op_i,
  input  logic [sci_pkg::ANG_W-1:0] angle_i,
  input  logic [sci_pkg::KEY_W-1:0] px_i,
  input  logic [sci_pkg::VAL_W-1:0] cm_i,
  input  logic                      out_ready_i,
  output sci_pkg::dp_stat_t         stat_o,
  output logic                      out_valid_o,
  output logic [sci_pkg::VAL_W-1:0] out_value_o
);

  localparam int SEC_SHIFT = 16;
  localparam int RECIP_W   = 11;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'((2 ** SEC_SHIFT + sci_pkg::SEC_SPAN - 1) / sci_pkg::SEC_SPAN);
  localparam int MEM_DEPTH = sci_pkg::SECTORS * sci_pkg::MAX_POINTS;

  logic [sci_pkg::OP_W-1:0]  op_q;
  logic [sci_pkg::SEC_W-1:0] sec_q;
  logic [sci_pkg::KEY_W-1:0] px_q;
  logic [sci_pkg::VAL_W-1:0] cm_q;
  logic [sci_pkg::CNT_W-1:0] cnt_q [sci_pkg::SECTORS];
  logic [sci_pkg::KEY_W-1:0] key_mem [MEM_DEPTH];
  logic [sci_pkg::VAL_W-1:0] val_mem [MEM_DEPTH];
  logic [sci_pkg::KEY_W-1:0] rd_key_q, k0_q, k1_q;
  logic [sci_pkg::VAL_W-1:0] rd_val_q, y0_q, y1_q;
  logic                      neg_q;
  logic [sci_pkg::VAL_W-1:0] res_q, res_d;
  logic                      out_valid_q;
  logic [sci_pkg::VAL_W-1:0] out_value_q;

  logic signed [sci_pkg::ANG_W:0] ang_ext, ang_red;
  logic [8:0]                     ang_pos;
  logic [8+RECIP_W:0]             sec_prod;
  logic [3:0]                     sec_raw;
  logic [sci_pkg::SEC_W-1:0]      sec_new;
  logic [sci_pkg::CNT_W-1:0]      cnt;
  logic [sci_pkg::KEY_W-1:0]      dx, dk;
  logic                           neg;
  logic [sci_pkg::VAL_W-1:0]      dy;
  logic [sci_pkg::DVD_W-1:0]      dvd, quo;
  logic                           div_done;
  logic [sci_pkg::VAL_W:0]        avg_sum, interp;

  // wrap the angle into 0..359, then divide by the sector span via reciprocal
  always_comb begin
    ang_ext = {angle_i[sci_pkg::ANG_W-1], angle_i};
    if (ang_ext < -11'sd360)      ang_red = ang_ext + 11'sd720;
    else if (ang_ext < 11'sd0)    ang_red = ang_ext + 11'sd360;
    else if (ang_ext >= 11'sd360) ang_red = ang_ext - 11'sd360;
    else                          ang_red = ang_ext;
    ang_pos  = ang_red[8:0];
    sec_prod = {{RECIP_W{1'b0}}, ang_pos} * {{9{1'b0}}, RECIP};
    sec_raw  = sec_prod[SEC_SHIFT+3:SEC_SHIFT];
    sec_new  = (sec_raw > 4'(sci_pkg::SECTORS - 1)) ? sci_pkg::SEC_W'(sci_pkg::SECTORS - 1)
                                                    : sec_raw[sci_pkg::SEC_W-1:0];
  end

  assign cnt = cnt_q[sec_q];

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= op_i;
      sec_q <= sec_new;
      px_q  <= px_i;
      cm_q  <= cm_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < sci_pkg::SECTORS; i++) cnt_q[i] <= '0;
    end else if (cmd_i.clr) begin
      for (int i = 0; i < sci_pkg::SECTORS; i++) cnt_q[i] <= '0;
    end else if (cmd_i.cnt_inc) begin
      cnt_q[sec_q] <= cnt + sci_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      key_mem[{sec_q, cmd_i.wr_idx}] <= cmd_i.wr_new ? px_q : rd_key_q;
      val_mem[{sec_q, cmd_i.wr_idx}] <= cmd_i.wr_new ? cm_q : rd_val_q;
    end
    if (cmd_i.rd_en) begin
      rd_key_q <= key_mem[{sec_q, cmd_i.rd_idx}];
      rd_val_q <= val_mem[{sec_q, cmd_i.rd_idx}];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.lat0) begin
      k0_q <= rd_key_q;
      y0_q <= rd_val_q;
    end
    if (cmd_i.lat1) begin
      k1_q <= rd_key_q;
      y1_q <= rd_val_q;
    end
    if (cmd_i.div_start) neg_q <= neg;
  end

  assign dx  = px_q - k0_q;
  assign dk  = k1_q - k0_q;
  assign neg = y1_q < y0_q;
  assign dy  = neg ? (y0_q - y1_q) : (y1_q - y0_q);
  assign dvd = {{sci_pkg::VAL_W{1'b0}}, dx} * {{sci_pkg::KEY_W{1'b0}}, dy};

  sci_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (dvd),
    .divisor_i  (dk),
    .quotient_o (quo),
    .done_o     (div_done)
  );

  assign avg_sum = {1'b0, y0_q} + {1'b0, y1_q};
  assign interp  = neg_q ? ({1'b0, y0_q} - quo[sci_pkg::VAL_W:0])
                         : ({1'b0, y0_q} + quo[sci_pkg::VAL_W:0]);

  always_comb begin
    case (cmd_i.res_sel)
      sci_pkg::RES_ZERO:      res_d = '0;
      sci_pkg::RES_COUNT:     res_d = sci_pkg::VAL_W'(cnt);
      sci_pkg::RES_COUNT_INC: res_d = sci_pkg::VAL_W'(cnt) + sci_pkg::VAL_W'(1);
      sci_pkg::RES_AVG:       res_d = avg_sum[sci_pkg::VAL_W:1];
      sci_pkg::RES_INTERP:    res_d = interp[sci_pkg::VAL_W-1:0];
      default:                res_d = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_en) res_q <= res_d;
    if (cmd_i.push) out_value_q <= res_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.push) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign stat_o.op       = op_q;
  assign stat_o.cnt      = cnt;
  assign stat_o.key_gt   = rd_key_q > px_q;
  assign stat_o.key_lt   = rd_key_q < px_q;
  assign stat_o.k_eq     = k1_q == k0_q;
  assign stat_o.div_done = div_done;
  assign stat_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_value_o = out_value_q;

endmodule

FILE: sv/sci_ctrl.sv
`timescale 1ns / 1ps
`include "sector_calibration_interpolator_defines.svh"
module sci_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  sci_pkg::dp_stat_t   stat_i,
  output sci_pkg::ctrl_cmd_t  cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_INS_CMP,
    S_INS_WR,
    S_Q_SCAN,
    S_Q_RD1,
    S_Q_LD,
    S_Q_MUL,
    S_Q_DIV,
    S_FINISH
  } state_e;

  state_e                    state_q, state_d;
  logic [sci_pkg::IDX_W-1:0] ptr_q, ptr_d;
  logic [sci_pkg::IDX_W-1:0] r_q, r_d;

  always_comb begin
    cmd_o      = '0;
    state_d    = state_q;
    ptr_d      = ptr_q;
    r_d        = r_q;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DECODE;
        end
      end
      S_DECODE: begin
        r_d = '0;
        case (stat_i.op)
          sci_pkg::OP_CLEAR: begin
            cmd_o.clr     = 1'b1;
            cmd_o.res_en  = 1'b1;
            cmd_o.res_sel = sci_pkg::RES_ZERO;
            state_d       = S_FINISH;
          end
          sci_pkg::OP_INSERT: begin
            ptr_d = stat_i.cnt;
            if (stat_i.cnt >= sci_pkg::FULL_CNT) begin
              cmd_o.res_en  = 1'b1;
              cmd_o.res_sel = sci_pkg::RES_COUNT;
              state_d       = S_FINISH;
            end else if (stat_i.cnt == '0) begin
              state_d = S_INS_WR;
            end else begin
              cmd_o.rd_en  = 1'b1;
              cmd_o.rd_idx = stat_i.cnt - sci_pkg::IDX_W'(1);
              state_d      = S_INS_CMP;
            end
          end
          sci_pkg::OP_QUERY: begin
            if (stat_i.cnt < sci_pkg::CNT_W'(2)) begin
              cmd_o.res_en  = 1'b1;
              cmd_o.res_sel = sci_pkg::RES_ZERO;
              state_d       = S_FINISH;
            end else begin
              cmd_o.rd_en  = 1'b1;
              cmd_o.rd_idx = '0;
              ptr_d        = '0;
              state_d      = S_Q_SCAN;
            end
          end
          default: begin
            cmd_o.res_en  = 1'b1;
            cmd_o.res_sel = sci_pkg::RES_ZERO;
            state_d       = S_FINISH;
          end
        endcase
      end
      S_INS_CMP: begin
        // move the larger key up one slot and look one further down
        if (stat_i.key_gt) begin
          cmd_o.wr_en  = 1'b1;
          cmd_o.wr_idx = ptr_q;
          ptr_d        = ptr_q - sci_pkg::IDX_W'(1);
          if (ptr_q == sci_pkg::IDX_W'(1)) begin
            state_d = S_INS_WR;
          end else begin
            cmd_o.rd_en  = 1'b1;
            cmd_o.rd_idx = ptr_q - sci_pkg::IDX_W'(2);
          end
        end else begin
          state_d = S_INS_WR;
        end
      end
      S_INS_WR: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.wr_new  = 1'b1;
        cmd_o.wr_idx  = ptr_q;
        cmd_o.cnt_inc = 1'b1;
        cmd_o.res_en  = 1'b1;
        cmd_o.res_sel = sci_pkg::RES_COUNT_INC;
        state_d       = S_FINISH;
      end
      S_Q_SCAN: begin
        if (ptr_q == '0 && stat_i.key_gt) begin
          cmd_o.res_en  = 1'b1;
          cmd_o.res_sel = sci_pkg::RES_ZERO;
          state_d       = S_FINISH;
        end else if (ptr_q == stat_i.cnt - sci_pkg::CNT_W'(1)) begin
          if (stat_i.key_lt) begin
            cmd_o.res_en  = 1'b1;
            cmd_o.res_sel = sci_pkg::RES_COUNT;
            state_d       = S_FINISH;
          end else begin
            cmd_o.rd_en  = 1'b1;
            cmd_o.rd_idx = r_q;
            state_d      = S_Q_RD1;
          end
        end else begin
          if (!stat_i.key_gt) r_d = ptr_q;
          ptr_d        = ptr_q + sci_pkg::IDX_W'(1);
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_idx = ptr_q + sci_pkg::IDX_W'(1);
        end
      end
      S_Q_RD1: begin
        cmd_o.lat0   = 1'b1;
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_idx = r_q + sci_pkg::IDX_W'(1);
        state_d      = S_Q_LD;
      end
      S_Q_LD: begin
        cmd_o.lat1 = 1'b1;
        state_d    = S_Q_MUL;
      end
      S_Q_MUL: begin
        if (stat_i.k_eq) begin
          cmd_o.res_en  = 1'b1;
          cmd_o.res_sel = sci_pkg::RES_AVG;
          state_d       = S_FINISH;
        end else begin
          cmd_o.div_start = 1'b1;
          state_d         = S_Q_DIV;
        end
      end
      S_Q_DIV: begin
        if (stat_i.div_done) begin
          cmd_o.res_en  = 1'b1;
          cmd_o.res_sel = sci_pkg::RES_INTERP;
          state_d       = S_FINISH;
        end
      end
      S_FINISH: begin
        if (stat_i.out_free) begin
          cmd_o.push = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ptr_q   <= '0;
      r_q     <= '0;
    end else begin
      state_q <= state_d;
      ptr_q   <= ptr_d;
      r_q     <= r_d;
    end
  end

  `SCI_ASSERT_IMP(a_push_free, cmd_o.push, stat_i.out_free, "result register overwritten")
  `SCI_ASSERT_IMP(a_scan_bound, state_q == S_Q_SCAN, ptr_q < stat_i.cnt, "scan past table end")
  `SCI_ASSERT_IMP(a_shift_ptr, state_q == S_INS_CMP, ptr_q != '0, "shift at slot zero")
  `SCI_ASSERT(a_cnt_max, stat_i.cnt <= sci_pkg::FULL_CNT, "sector count overflow")

endmodule
